// ===== design/fpa_pkg.sv =====
`timescale 1ns / 1ps

package fpa_pkg;

  // Width of one raw operand or result word.
  localparam int DATA_W = 32;

  // Default number format, Q24.8.
  localparam int FRAC_BITS_DEF = 8;
  localparam int INT_BITS_DEF = 24;

  // Quotient bits retired by one divider stage.
  localparam int DIV_STEP_BITS = 4;

  // Operation codes.
  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_INC = 4'd4;
  localparam logic [3:0] OP_DEC = 4'd5;
  localparam logic [3:0] OP_GT = 4'd6;
  localparam logic [3:0] OP_GE = 4'd7;
  localparam logic [3:0] OP_LT = 4'd8;
  localparam logic [3:0] OP_LE = 4'd9;
  localparam logic [3:0] OP_EQ = 4'd10;
  localparam logic [3:0] OP_NE = 4'd11;
  localparam logic [3:0] OP_MIN = 4'd12;
  localparam logic [3:0] OP_MAX = 4'd13;
  localparam logic [3:0] OP_FROM_INT = 4'd14;
  localparam logic [3:0] OP_TO_INT = 4'd15;

  // Per-item information that rides alongside the divider.
  typedef struct packed {
    logic [3:0]        op;
    logic [DATA_W-1:0] res;
    logic              ovf;
    logic              cond;
    logic              neg;
    logic [DATA_W-1:0] mag_a;
  } side_t;

endpackage

// ===== design/fixed_point_q24_8_alu.sv =====
`timescale 1ns / 1ps
// Signed fixed-point ALU, one result per accepted item.
// Path: input register, stage 1, the divider stages, stage 2, stage 3 and the output register;
// the default format is Q24.8, and the divider retires four quotient bits per stage.
// Throughput: one item per cycle; a stall at the output freezes the whole pipeline.
// Reset (synchronous, active low) clears all valid bits; no results are pending after it.

module fixed_point_q24_8_alu #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
  parameter int INT_BITS = fpa_pkg::INT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // operand_a [31:0], operand_b [63:32]
  input  logic [3:0]  in_tuser,  // op [3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // result_value [31:0]
  output logic [1:0]  out_tuser  // overflow [0], condition [1]
);
  import fpa_pkg::*;

  localparam int NUM_W = DATA_W + FRAC_BITS;
  localparam int PW = ((NUM_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS) * DIV_STEP_BITS;
  localparam int E_RAW = INT_BITS - 1 + FRAC_BITS;
  localparam int E = (E_RAW > 31) ? 31 : E_RAW;
  localparam logic [63:0] LIM = 64'(1) << E;

  logic en;

  // Stage 0: input register.
  logic                     v0_r;
  logic [3:0]               op0_r;
  logic signed [DATA_W-1:0] a0_r;
  logic signed [DATA_W-1:0] b0_r;

  // Stage 1: magnitudes and the simple operations.
  logic              v1_r;
  side_t             side1_r;
  side_t             side1_nxt;
  logic [DATA_W-1:0] mb1_r;
  logic [DATA_W-1:0] ma_c;
  logic [DATA_W-1:0] mb_c;

  // Divider outputs.
  logic                 vd;
  logic [PW-1:0]        quo_d;
  logic [DATA_W-1:0]    rem_d;
  logic [DATA_W-1:0]    den_d;
  logic [$bits(side_t)-1:0] side_d_bits;
  side_t                side_d;

  // Stage 2: product and division rounding.
  logic        v2_r;
  side_t       side2_r;
  logic [63:0] prod2_r;
  logic [PW-1:0] quo2_r;
  logic        rnd2_r;
  logic        dz2_r;

  // Stage 3: rounded magnitude.
  logic        v3_r;
  side_t       side3_r;
  logic [63:0] mag3_r;
  logic [63:0] mag3_nxt;
  logic        dz3_r;

  // Output register.
  logic              out_valid_r;
  logic [DATA_W-1:0] res_r;
  logic              ovf_r;
  logic              cond_r;
  logic [DATA_W-1:0] res_nxt;
  logic              ovf_nxt;
  logic              cond_nxt;

  // The pipeline advances whenever the output register is free or being drained.
  assign en = !out_valid_r || out_tready;
  assign in_tready = en;

  // Valid bits of the top-level stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r;
      v2_r <= vd;
      v3_r <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  // Input capture.
  always_ff @(posedge clk) begin
    if (en) begin
      op0_r <= in_tuser;
      a0_r <= in_tdata[31:0];
      b0_r <= in_tdata[63:32];
    end
  end

  // Simple operations are finished here; others get magnitudes and sign.
  always_comb begin
    logic [DATA_W:0] sum;
    logic [DATA_W:0] dif;
    sum = {a0_r[DATA_W-1], a0_r} + {b0_r[DATA_W-1], b0_r};
    dif = {a0_r[DATA_W-1], a0_r} - {b0_r[DATA_W-1], b0_r};
    ma_c = a0_r[DATA_W-1] ? DATA_W'(-a0_r) : DATA_W'(a0_r);
    mb_c = b0_r[DATA_W-1] ? DATA_W'(-b0_r) : DATA_W'(b0_r);
    side1_nxt.op = op0_r;
    side1_nxt.res = '0;
    side1_nxt.ovf = 1'b0;
    side1_nxt.cond = 1'b0;
    side1_nxt.neg = a0_r[DATA_W-1] ^ b0_r[DATA_W-1];
    side1_nxt.mag_a = ma_c;
    unique case (op0_r)
      OP_ADD: begin
        side1_nxt.ovf = sum[DATA_W] != sum[DATA_W-1];
        side1_nxt.res = side1_nxt.ovf ? '0 : sum[DATA_W-1:0];
      end
      OP_SUB: begin
        side1_nxt.ovf = dif[DATA_W] != dif[DATA_W-1];
        side1_nxt.res = side1_nxt.ovf ? '0 : dif[DATA_W-1:0];
      end
      OP_INC: begin
        side1_nxt.ovf = (a0_r == {1'b0, {(DATA_W-1){1'b1}}});
        side1_nxt.res = side1_nxt.ovf ? '0 : DATA_W'(a0_r + 1);
      end
      OP_DEC: begin
        side1_nxt.ovf = (a0_r == {1'b1, {(DATA_W-1){1'b0}}});
        side1_nxt.res = side1_nxt.ovf ? '0 : DATA_W'(a0_r - 1);
      end
      OP_GT: side1_nxt.cond = a0_r > b0_r;
      OP_GE: side1_nxt.cond = a0_r >= b0_r;
      OP_LT: side1_nxt.cond = a0_r < b0_r;
      OP_LE: side1_nxt.cond = a0_r <= b0_r;
      OP_EQ: side1_nxt.cond = a0_r == b0_r;
      OP_NE: side1_nxt.cond = a0_r != b0_r;
      OP_MIN: side1_nxt.res = (a0_r < b0_r) ? a0_r : b0_r;
      OP_MAX: side1_nxt.res = (a0_r > b0_r) ? a0_r : b0_r;
      OP_FROM_INT: side1_nxt.neg = a0_r[DATA_W-1];
      OP_TO_INT: side1_nxt.res = DATA_W'(a0_r >>> FRAC_BITS);
      OP_MUL, OP_DIV: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= side1_nxt;
      mb1_r <= mb_c;
    end
  end

  // Pipelined divider; every item passes through it to keep one latency.
  fpa_div #(
    .FRAC_BITS(FRAC_BITS),
    .SIDE_W($bits(side_t))
  ) u_div (
    .clk(clk),
    .rst_n(rst_n),
    .en(en),
    .in_valid(v1_r),
    .num({side1_r.mag_a, {FRAC_BITS{1'b0}}}),
    .den(mb1_r),
    .side_in(side1_r),
    .out_valid(vd),
    .quo(quo_d),
    .rem(rem_d),
    .den_out(den_d),
    .side_out(side_d_bits)
  );

  assign side_d = side_t'(side_d_bits);

  // Stage 2: multiply magnitudes and decide division rounding.
  always_ff @(posedge clk) begin
    if (en) begin
      side2_r <= side_d;
      prod2_r <= 64'(side_d.mag_a) * 64'(den_d);
      quo2_r <= quo_d;
      rnd2_r <= {rem_d, 1'b0} >= {1'b0, den_d};
      dz2_r <= (den_d == '0);
    end
  end

  // Stage 3: rounded magnitude of the result.
  always_comb begin
    unique case (side2_r.op)
      OP_MUL: mag3_nxt = (prod2_r >> FRAC_BITS) + 64'(prod2_r[FRAC_BITS-1]);
      OP_DIV: mag3_nxt = 64'(quo2_r) + 64'(rnd2_r);
      default: mag3_nxt = 64'(side2_r.mag_a) << FRAC_BITS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r <= side2_r;
      mag3_r <= mag3_nxt;
      dz3_r <= dz2_r && (side2_r.op == OP_DIV);
    end
  end

  // Range check of the fixed-point results and final selection.
  always_comb begin
    logic fit_ok;
    fit_ok = side3_r.neg ? (mag3_r <= LIM) : (mag3_r < LIM);
    res_nxt = side3_r.res;
    ovf_nxt = side3_r.ovf;
    cond_nxt = side3_r.cond;
    if (side3_r.op == OP_MUL || side3_r.op == OP_DIV || side3_r.op == OP_FROM_INT) begin
      ovf_nxt = dz3_r || !fit_ok;
      cond_nxt = 1'b0;
      if (ovf_nxt) begin
        res_nxt = '0;
      end else if (side3_r.neg) begin
        res_nxt = DATA_W'(-mag3_r[DATA_W-1:0]);
      end else begin
        res_nxt = mag3_r[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      ovf_r <= ovf_nxt;
      cond_r <= cond_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = res_r;
  assign out_tuser = {cond_r, ovf_r};

`ifndef SYNTHESIS
  // An overflowed result is always forced to zero.
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata == '0) && !out_tuser[1])
    else $error("overflow with nonzero result or condition");

  // A true comparison carries a zero result and no overflow.
  a_cond_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> (out_tdata == '0) && !out_tuser[0])
    else $error("condition set with nonzero result or overflow");

  // While stalled, the last internal stage holds its valid bit.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v3_r))
    else $error("pipeline moved during a stall");
`endif

endmodule

// ===== design/fpa_div.sv =====
`timescale 1ns / 1ps

module fpa_div #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
  parameter int SIDE_W = $bits(fpa_pkg::side_t)
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [fpa_pkg::DATA_W+FRAC_BITS-1:0]   num,
  input  logic [fpa_pkg::DATA_W-1:0]             den,
  input  logic [SIDE_W-1:0]                      side_in,
  output logic                                   out_valid,
  output logic [((fpa_pkg::DATA_W+FRAC_BITS+fpa_pkg::DIV_STEP_BITS-1)
                 / fpa_pkg::DIV_STEP_BITS) * fpa_pkg::DIV_STEP_BITS - 1:0] quo,
  output logic [fpa_pkg::DATA_W-1:0]             rem,
  output logic [fpa_pkg::DATA_W-1:0]             den_out,
  output logic [SIDE_W-1:0]                      side_out
);
  import fpa_pkg::*;

  localparam int NUM_W = DATA_W + FRAC_BITS;
  localparam int STAGES = (NUM_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int PW = STAGES * DIV_STEP_BITS;

  logic              v_r    [STAGES];
  logic [PW-1:0]     num_r  [STAGES];
  logic [PW-1:0]     quo_r  [STAGES];
  logic [DATA_W-1:0] rem_r  [STAGES];
  logic [DATA_W-1:0] den_r  [STAGES];
  logic [SIDE_W-1:0] side_r [STAGES];

  genvar i;
  generate
    for (i = 0; i < STAGES; i++) begin : g_stage
      logic              v_in;
      logic [PW-1:0]     num_in;
      logic [PW-1:0]     quo_in;
      logic [DATA_W-1:0] rem_in;
      logic [DATA_W-1:0] den_in;
      logic [SIDE_W-1:0] side_in_s;
      logic [PW-1:0]     num_nxt;
      logic [PW-1:0]     quo_nxt;
      logic [DATA_W-1:0] rem_nxt;

      // Stage inputs come from the ports or from the previous stage.
      if (i == 0) begin : g_first
        assign v_in = in_valid;
        assign num_in = PW'(num);
        assign quo_in = '0;
        assign rem_in = '0;
        assign den_in = den;
        assign side_in_s = side_in;
      end else begin : g_next
        assign v_in = v_r[i-1];
        assign num_in = num_r[i-1];
        assign quo_in = quo_r[i-1];
        assign rem_in = rem_r[i-1];
        assign den_in = den_r[i-1];
        assign side_in_s = side_r[i-1];
      end

      // Restoring division, a few quotient bits per stage, MSB first.
      always_comb begin
        logic [DATA_W:0] t;
        logic            ge;
        num_nxt = num_in;
        quo_nxt = quo_in;
        rem_nxt = rem_in;
        for (int k = 0; k < DIV_STEP_BITS; k++) begin
          t = {rem_nxt, num_nxt[PW-1]};
          num_nxt = {num_nxt[PW-2:0], 1'b0};
          ge = (t >= {1'b0, den_in});
          if (ge) begin
            t = t - {1'b0, den_in};
          end
          quo_nxt = {quo_nxt[PW-2:0], ge};
          rem_nxt = t[DATA_W-1:0];
        end
      end

      // Valid bit of this stage.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i] <= 1'b0;
        end else if (en) begin
          v_r[i] <= v_in;
        end
      end

      // Data of this stage.
      always_ff @(posedge clk) begin
        if (en) begin
          num_r[i] <= num_nxt;
          quo_r[i] <= quo_nxt;
          rem_r[i] <= rem_nxt;
          den_r[i] <= den_in;
          side_r[i] <= side_in_s;
        end
      end
    end
  endgenerate

  assign out_valid = v_r[STAGES-1];
  assign quo = quo_r[STAGES-1];
  assign rem = rem_r[STAGES-1];
  assign den_out = den_r[STAGES-1];
  assign side_out = side_r[STAGES-1];

endmodule

// ===== tb/fixed_point_q24_8_alu_tb.sv =====
`timescale 1ns / 1ps

module fixed_point_q24_8_alu_tb;
  import fpa_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int RANGE_EXP = (INT_BITS_DEF - 1 + FRAC > 31) ? 31 : INT_BITS_DEF - 1 + FRAC;
  localparam int LATENCY = 15;

  typedef struct packed {
    logic [31:0] value;
    logic        ovf;
    logic        cond;
  } alu_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [3:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  alu_result_t pending_results[$];
  int          error_count = 0;
  int          result_count = 0;
  int          item_count = 0;
  bit          stall_enable = 1'b1;

  fixed_point_q24_8_alu dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Fits a signed magnitude into the Q range; returns 0 when it does not fit.
  function automatic bit fit_q_range(input bit neg, input logic [63:0] mag,
                                     output logic [63:0] raw);
    logic [63:0] lim;
    lim = 64'd1 << RANGE_EXP;
    raw = '0;
    if (neg) begin
      if (mag > lim) return 1'b0;
      raw = -mag;
    end else begin
      if (mag > lim - 1) return 1'b0;
      raw = mag;
    end
    return 1'b1;
  endfunction

  // Computes the expected result of one operation.
  function automatic alu_result_t alu_compute(input logic [3:0] op, input logic [31:0] ra,
                                              input logic [31:0] rb);
    longint      a, b, wide;
    logic [63:0] ma, mb, p, q, n, r, raw;
    bit          neg, ovf, cond;
    alu_result_t res;
    a = longint'($signed(ra));
    b = longint'($signed(rb));
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    neg = (a < 0) != (b < 0);
    ovf = 1'b0;
    cond = 1'b0;
    raw = '0;
    case (op)
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        case (op)
          OP_ADD:  wide = a + b;
          OP_SUB:  wide = a - b;
          OP_INC:  wide = a + 1;
          default: wide = a - 1;
        endcase
        ovf = wide > 64'sd2147483647 || wide < -64'sd2147483648;
        raw = wide;
      end
      OP_MUL: begin
        p = ma * mb;
        q = (p >> FRAC) + ((p >> (FRAC - 1)) & 64'd1);
        if (q == 0) neg = 1'b0;
        ovf = !fit_q_range(neg, q, raw);
      end
      OP_DIV: begin
        if (mb == 0) begin
          ovf = 1'b1;
        end else begin
          n = ma << FRAC;
          q = n / mb;
          r = n % mb;
          if (2 * r >= mb) q++;
          if (q == 0) neg = 1'b0;
          ovf = !fit_q_range(neg, q, raw);
        end
      end
      OP_GT: cond = a > b;
      OP_GE: cond = a >= b;
      OP_LT: cond = a < b;
      OP_LE: cond = a <= b;
      OP_EQ: cond = a == b;
      OP_NE: cond = a != b;
      OP_MIN: raw = a < b ? a : b;
      OP_MAX: raw = a > b ? a : b;
      OP_FROM_INT: ovf = !fit_q_range(a < 0, ma << FRAC, raw);
      default: begin
        if (a < 0) raw = -((ma + ((64'd1 << FRAC) - 1)) >> FRAC);
        else raw = ma >> FRAC;
      end
    endcase
    res.value = ovf ? 32'd0 : raw[31:0];
    res.ovf = ovf;
    res.cond = cond;
    return res;
  endfunction

  // Sends one item after a random gap and records its expected result.
  // Valid stays high after the transfer so that a following item can go back to back.
  task automatic send_item(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
    int gap;
    gap = stall_enable ? $urandom_range(0, 11) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {b, a};
    pending_results.push_back(alu_compute(op, a, b));
    item_count++;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Receiver stall pattern, changed at the falling edge.
  initial begin
    int hold;
    forever begin
      @(negedge clk);
      hold = $urandom_range(0, 11);
      if (stall_enable && $urandom_range(0, 2) == 0 && hold != 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Compares each result transfer with the oldest expectation.
  always @(posedge clk) begin
    alu_result_t expected;
    if (rst_n && out_tvalid && out_tready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%h tuser=%b", $time, out_tdata, out_tuser);
        error_count++;
      end else begin
        expected = pending_results.pop_front();
        if (out_tdata !== expected.value) begin
          $display("%0t: result_value expected %h actual %h", $time, expected.value, out_tdata);
          error_count++;
        end
        if (out_tuser[0] !== expected.ovf) begin
          $display("%0t: overflow expected %b actual %b", $time, expected.ovf, out_tuser[0]);
          error_count++;
        end
        if (out_tuser[1] !== expected.cond) begin
          $display("%0t: condition expected %b actual %b", $time, expected.cond, out_tuser[1]);
          error_count++;
        end
      end
    end
  end

  // Stops sending and waits until every expected result has arrived.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Operand extremes across every operation, plus the named corner cases.
  task automatic test_directed();
    logic [31:0] edges[6];
    edges = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF, 32'h00000100, 32'hFFFFFF00};
    for (int op = 0; op < 16; op++)
      send_item(op[3:0], edges[$urandom_range(0, 5)], edges[$urandom_range(0, 5)]);
    send_item(OP_DIV, 32'h00000500, 32'h0);
    send_item(OP_MUL, 32'h00000080, 32'h00000001);
    send_item(OP_MUL, 32'hFFFFFF80, 32'h00000001);
    send_item(OP_DIV, 32'h80000000, 32'h00000080);
    send_item(OP_FROM_INT, 32'hFF800000, 32'h0);
    send_item(OP_FROM_INT, 32'h00800000, 32'h0);
    send_item(OP_TO_INT, 32'hFFFFFF01, 32'h0);
    send_item(OP_EQ, 32'h12345678, 32'h12345678);
  endtask

  // Sends twenty items in groups of five, pausing the sender until the pipeline has emptied before each group.
  task automatic test_drain_pause();
    wait_drained();
    for (int i = 0; i < 20; i++) begin
      send_item(i[3:0], $urandom, $urandom);
      if (i % 5 == 4) wait_drained();
    end
  endtask

  // Random operations with operands of mixed magnitude.
  task automatic test_random(input int count);
    logic [31:0] a, b;
    for (int i = 0; i < count; i++) begin
      a = $urandom;
      b = $urandom;
      case ($urandom_range(0, 3))
        0: a = $signed(a) >>> $urandom_range(8, 30);
        1: b = $signed(b) >>> $urandom_range(8, 30);
        2: begin
          a = $signed(a) >>> $urandom_range(12, 30);
          b = $signed(b) >>> $urandom_range(12, 30);
        end
        default: ;
      endcase
      if ($urandom_range(0, 15) == 0) b = a;
      send_item(4'($urandom_range(0, 15)), a, b);
    end
  endtask

  task automatic test_back_to_back();
    stall_enable = 1'b0;
    test_random(300);
    stall_enable = 1'b1;
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_drain_pause();
    test_random(1100);
    test_back_to_back();
    test_random(250);
    wait_drained();
    repeat (LATENCY * 2) @(negedge clk);
    $display("Covered %0d items over all 16 operations, %0d results checked,",
             item_count, result_count);
    $display("with random gaps on both sides and one back-to-back stretch.");
    if (error_count == 0 && pending_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
design/fpa_pkg.sv
design/fpa_div.sv
design/fixed_point_q24_8_alu.sv
tb/fixed_point_q24_8_alu_tb.sv
